>>> rtl/ats_pkg.sv
// Shared types and constants for the alias-table sampler.
package ats_pkg;

    localparam int SLOT_BITS   = 8;
    localparam int DEPTH       = 256;
    localparam int CNT_BITS    = 9;
    localparam int WEIGHT_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int VAL_BITS    = 24;
    localparam int PROD_BITS   = FRAC_BITS + VAL_BITS;

    typedef enum logic [1:0] {
        FN_WRITE  = 2'd0,
        FN_BUILD  = 2'd1,
        FN_LOOKUP = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        RS_OK         = 2'd0,
        RS_ZERO_TOTAL = 2'd1,
        RS_RANGE      = 2'd2,
        RS_NOT_BUILT  = 2'd3
    } res_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_SUM,
        S_INIT,
        S_PAIR_Q,
        S_PAIR_S,
        S_PAIR_W,
        S_LK_RD,
        S_LK_RES,
        S_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic write_weight;
        logic pass_step;
        logic sum_phase;
        logic init_phase;
        logic init_start;
        logic build_fail;
        logic build_ok;
        logic pair_pop;
        logic pair_write;
        logic lk_mul;
        logic res_clear;
        logic res_zero_total;
        logic res_lookup;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic pass_done;
        logic acc_zero;
        logic small_empty;
        logic large_empty;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/ats_queue.sv
// Circular index queue used for the small and large lists during a build.
module ats_queue
    import ats_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clear,
    input  logic                 push,
    input  logic [SLOT_BITS-1:0] push_data,
    input  logic                 pop,
    output logic [SLOT_BITS-1:0] pop_data,
    output logic                 empty
);

    logic [SLOT_BITS-1:0] mem [DEPTH];
    logic [SLOT_BITS-1:0] head_reg, head_next;
    logic [SLOT_BITS-1:0] tail_reg, tail_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [SLOT_BITS-1:0] rd_reg;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (clear) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end else begin
            if (push) tail_next = tail_reg + 1'b1;
            if (pop)  head_next = head_reg + 1'b1;
            if (push && !pop) count_next = count_reg + 1'b1;
            else if (pop && !push) count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !clear) mem[tail_reg] <= push_data;
        if (pop) rd_reg <= mem[head_reg];
    end

    assign pop_data = rd_reg;
    assign empty    = (count_reg == '0);

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> count_reg != CNT_BITS'(DEPTH)) else $error("push to full queue");
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        clear |=> count_reg == '0) else $error("clear left entries");
`endif

endmodule

>>> rtl/ats_ctrl.sv
// Sequencing state machine: item dispatch, build passes, pairing and lookup.
module ats_ctrl
    import ats_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] s_tuser,
    output logic       s_tready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    unique case (s_tuser)
                        FN_WRITE:  state_next = S_WRITE;
                        FN_BUILD:  state_next = S_SUM;
                        FN_LOOKUP: state_next = S_LK_RD;
                        default: begin
                            cmd.res_clear = 1'b1;
                            state_next    = S_RESP;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                cmd.write_weight = 1'b1;
                cmd.res_clear    = 1'b1;
                state_next       = S_RESP;
            end
            S_SUM: begin
                cmd.sum_phase = 1'b1;
                if (st.pass_done) begin
                    if (st.acc_zero) begin
                        cmd.build_fail     = 1'b1;
                        cmd.res_zero_total = 1'b1;
                        state_next         = S_RESP;
                    end else begin
                        cmd.init_start = 1'b1;
                        state_next     = S_INIT;
                    end
                end else begin
                    cmd.pass_step = 1'b1;
                end
            end
            S_INIT: begin
                cmd.init_phase = 1'b1;
                if (st.pass_done) state_next = S_PAIR_Q;
                else              cmd.pass_step = 1'b1;
            end
            S_PAIR_Q: begin
                if (st.small_empty || st.large_empty) begin
                    cmd.build_ok  = 1'b1;
                    cmd.res_clear = 1'b1;
                    state_next    = S_RESP;
                end else begin
                    cmd.pair_pop = 1'b1;
                    state_next   = S_PAIR_S;
                end
            end
            S_PAIR_S: state_next = S_PAIR_W;
            S_PAIR_W: begin
                cmd.pair_write = 1'b1;
                state_next     = S_PAIR_Q;
            end
            S_LK_RD: begin
                cmd.lk_mul = 1'b1;
                state_next = S_LK_RES;
            end
            S_LK_RES: begin
                cmd.res_lookup = 1'b1;
                state_next     = S_RESP;
            end
            S_RESP: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_resp_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && st.out_free) |=> state_reg == S_IDLE)
        else $error("result word not handed over");
    a_pair_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PAIR_W) |-> $past(state_reg) == S_PAIR_S)
        else $error("pair write without read");
    a_build_starts_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == FN_BUILD) |=> state_reg == S_SUM)
        else $error("build did not start summing");
`endif

endmodule

>>> rtl/ats_dp.sv
// Datapath: weight, scaled, threshold and alias stores, queues, lookup compare.
module ats_dp
    import ats_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [CNT_BITS-1:0]    entry_count,
    input  logic [39:0]            s_tdata,
    input  dp_cmd_t                cmd,
    output dp_status_t             st,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [SLOT_BITS-1:0]   m_index,
    output logic [1:0]             m_status
);

    logic [WEIGHT_BITS-1:0] weight_mem [DEPTH];
    logic [VAL_BITS-1:0]    scaled_mem [DEPTH];
    logic [VAL_BITS-1:0]    thr_mem    [DEPTH];
    logic [SLOT_BITS-1:0]   alias_mem  [DEPTH];

    logic [SLOT_BITS-1:0]   slot_reg;
    logic [WEIGHT_BITS-1:0] weight_reg;
    logic [FRAC_BITS-1:0]   frac_reg;

    logic [CNT_BITS-1:0]    n_reg, built_count_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic                   rdv_reg;
    logic [SLOT_BITS-1:0]   idx_d_reg;
    logic [WEIGHT_BITS-1:0] w_rd_reg;
    logic [VAL_BITS-1:0]    acc_reg, total_reg;
    logic                   built_reg;

    logic [SLOT_BITS-1:0]   s_idx_reg, g_idx_reg;
    logic [VAL_BITS-1:0]    sc_s_reg, sc_g_reg;
    logic [VAL_BITS-1:0]    thr_rd_reg;
    logic [SLOT_BITS-1:0]   alias_rd_reg;
    logic [PROD_BITS-1:0]   prod_reg;

    logic [SLOT_BITS-1:0]   res_index_reg;
    logic [1:0]             res_status_reg;
    logic                   m_valid_reg;
    logic [SLOT_BITS-1:0]   m_index_reg;
    logic [1:0]             m_status_reg;

    logic [CNT_BITS-1:0]    n_clamped;
    logic [VAL_BITS-1:0]    scaled_init;
    logic                   init_wr;
    logic [VAL_BITS:0]      g_sum;
    logic [VAL_BITS-1:0]    g_new;
    logic                   small_push, large_push;
    logic [SLOT_BITS-1:0]   q_push_data;
    logic [SLOT_BITS-1:0]   small_head, large_head;
    logic                   small_empty, large_empty;

    always_comb begin
        if (entry_count == '0)                      n_clamped = CNT_BITS'(1);
        else if (entry_count > CNT_BITS'(DEPTH))    n_clamped = CNT_BITS'(DEPTH);
        else                                        n_clamped = entry_count;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            slot_reg   <= s_tdata[7:0];
            weight_reg <= s_tdata[23:8];
            frac_reg   <= s_tdata[39:24];
            n_reg      <= n_clamped;
        end
    end

    // Streaming pass over slots 0..n-1 through the registered weight read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rdv_reg <= 1'b0;
        end else if (cmd.capture || cmd.init_start) begin
            cnt_reg <= '0;
            rdv_reg <= 1'b0;
        end else if (cmd.pass_step && cnt_reg < n_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            rdv_reg <= 1'b1;
        end else begin
            rdv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_weight) weight_mem[slot_reg] <= weight_reg;
        w_rd_reg  <= weight_mem[cnt_reg[SLOT_BITS-1:0]];
        idx_d_reg <= cnt_reg[SLOT_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture)                 acc_reg <= '0;
        else if (cmd.sum_phase && rdv_reg) acc_reg <= acc_reg + VAL_BITS'(w_rd_reg);
        if (cmd.init_start) total_reg <= acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            built_reg       <= 1'b0;
            built_count_reg <= '0;
        end else if (cmd.build_fail) begin
            built_reg <= 1'b0;
        end else if (cmd.build_ok) begin
            built_reg       <= 1'b1;
            built_count_reg <= n_reg;
        end
    end

    assign scaled_init = VAL_BITS'(w_rd_reg * n_reg);
    assign init_wr     = cmd.init_phase && rdv_reg;
    assign g_sum       = {1'b0, sc_g_reg} + {1'b0, sc_s_reg} - {1'b0, total_reg};
    assign g_new       = g_sum[VAL_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (init_wr) begin
            scaled_mem[idx_d_reg] <= scaled_init;
            thr_mem[idx_d_reg]    <= total_reg;
            alias_mem[idx_d_reg]  <= '0;
        end else if (cmd.pair_write) begin
            scaled_mem[g_idx_reg] <= g_new;
            thr_mem[s_idx_reg]    <= sc_s_reg;
            alias_mem[s_idx_reg]  <= g_idx_reg;
        end
        s_idx_reg    <= small_head;
        g_idx_reg    <= large_head;
        sc_s_reg     <= scaled_mem[small_head];
        sc_g_reg     <= scaled_mem[large_head];
        thr_rd_reg   <= thr_mem[slot_reg];
        alias_rd_reg <= alias_mem[slot_reg];
    end

    always_comb begin
        small_push  = 1'b0;
        large_push  = 1'b0;
        q_push_data = g_idx_reg;
        if (init_wr) begin
            q_push_data = idx_d_reg;
            small_push  = (scaled_init < total_reg);
            large_push  = !(scaled_init < total_reg);
        end else if (cmd.pair_write) begin
            small_push = (g_new < total_reg);
            large_push = !(g_new < total_reg);
        end
    end

    ats_queue u_small (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (cmd.init_start),
        .push      (small_push),
        .push_data (q_push_data),
        .pop       (cmd.pair_pop),
        .pop_data  (small_head),
        .empty     (small_empty)
    );

    ats_queue u_large (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (cmd.init_start),
        .push      (large_push),
        .push_data (q_push_data),
        .pop       (cmd.pair_pop),
        .pop_data  (large_head),
        .empty     (large_empty)
    );

    always_ff @(posedge aclk) begin
        if (cmd.lk_mul) prod_reg <= frac_reg * total_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_clear || cmd.res_zero_total) begin
            res_index_reg  <= '0;
            res_status_reg <= cmd.res_zero_total ? RS_ZERO_TOTAL : RS_OK;
        end else if (cmd.res_lookup) begin
            res_index_reg <= '0;
            if (!built_reg) begin
                res_status_reg <= RS_NOT_BUILT;
            end else if ({1'b0, slot_reg} >= built_count_reg) begin
                res_status_reg <= RS_RANGE;
            end else begin
                res_status_reg <= RS_OK;
                res_index_reg  <= (prod_reg < {thr_rd_reg, FRAC_BITS'(0)}) ?
                                  slot_reg : alias_rd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)          m_valid_reg <= 1'b0;
        else if (cmd.out_load) m_valid_reg <= 1'b1;
        else if (m_tready)     m_valid_reg <= 1'b0;
        if (cmd.out_load) begin
            m_index_reg  <= res_index_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign st.pass_done   = (cnt_reg == n_reg) && !rdv_reg;
    assign st.acc_zero    = (acc_reg == '0);
    assign st.small_empty = small_empty;
    assign st.large_empty = large_empty;
    assign st.out_free    = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_index  = m_index_reg;
    assign m_status = m_status_reg;

`ifndef SYNTHESIS
    a_pass_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sum_phase || cmd.init_phase) |-> cnt_reg <= n_reg)
        else $error("pass counter ran past slot count");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("result word overwritten");
    a_pair_pop_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pair_pop |-> (!small_empty && !large_empty))
        else $error("pairing with an empty list");
`endif

endmodule

>>> rtl/alias_table_sampler.sv
// Alias-table sampler top level: configuration register, controller and datapath.
// Usage:
//   Input words on s_*: s_tuser selects the operation (write weight, build,
//   lookup); s_tdata carries slot index, weight and uniform fraction.
//   One result word per input word on m_*: m_tdata is the chosen slot,
//   m_tuser the status (ok, zero total, out of range, not built).
//   cfg_wen/cfg_wdata set the slot count used by the next build; write it
//   only while the block is idle.
// Timing:
//   One word is worked on at a time; s_tready is high only when idle.
//   Write stores the weight, then loads its result; an unused code loads its result
//   directly. Lookup: registered table read and multiply, then compare. s_tready returns the cycle after
//   the result is loaded. Build: one pass sums the weights, a second pass
//   scales and sorts slots into the small/large lists, then each pairing step
//   (at most n-1 steps) runs through S_PAIR_Q, S_PAIR_S and S_PAIR_W for the
//   registered list reads and the registered scaled-value reads.
//   The finished result sits in an output register, so the next word is
//   taken while it waits; a stalled m_tready holds the block only at its
//   following result.
// Reset: synchronous, clears control state, the built flag and the output;
//   the slot count returns to 1. Stores need no clearing pass.
module alias_table_sampler
    import ats_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wen,
    input  logic [CNT_BITS-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,   // slot_index[7:0], weight[23:8], uniform_fraction[39:24]
    input  logic [1:0]          s_tuser,   // func[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // chosen_index[7:0]
    output logic [1:0]          m_tuser    // status[1:0]
);

    logic [CNT_BITS-1:0] entry_count_reg;
    dp_cmd_t             cmd;
    dp_status_t          st;

    always_ff @(posedge aclk) begin
        if (!aresetn)     entry_count_reg <= CNT_BITS'(1);
        else if (cfg_wen) entry_count_reg <= cfg_wdata;
    end

    ats_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ats_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .entry_count (entry_count_reg),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .st          (st),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_index     (m_tdata),
        .m_status    (m_tuser)
    );

endmodule

>>> bench/alias_table_sampler_tb.sv
// Self-checking bench for the alias-table sampler: directed table and sequences, then random traffic.
module alias_table_sampler_tb;
    import ats_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [1:0]  fn;
        logic [7:0]  slot;
        logic [15:0] wt;
        logic [15:0] frac;
        bit          fixed;
        logic [7:0]  want_idx;
        logic [1:0]  want_st;
    } dir_row_t;

    typedef struct {
        logic [7:0] idx;
        logic [1:0] st;
    } pick_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wen = 1'b0;
    logic [CNT_BITS-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;

    // predictor state
    logic [15:0] w_mem [DEPTH];
    logic [23:0] thr_mem [DEPTH];
    logic [7:0]  ali_mem [DEPTH];
    logic [23:0] tot_w;
    bit          built;
    int          built_n;
    int          slot_count;

    pick_t picks_due[$];
    int    errors = 0;
    longint cycles = 0;

    alias_table_sampler u_top (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stall pattern: runs of ready and stalled stretches
    int stall_mode = 0;
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ~m_tready;
            endcase
            if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        end
    end

    always @(posedge aclk) begin
        pick_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (picks_due.size() == 0) begin
                $error("result word with nothing expected: idx %0d st %0d", m_tdata, m_tuser);
                errors++;
            end else begin
                e = picks_due.pop_front();
                if (m_tdata !== e.idx) begin
                    $error("chosen_index: expected %0d, got %0d", e.idx, m_tdata);
                    errors++;
                end
                if (m_tuser !== e.st) begin
                    $error("status: expected %0d, got %0d", e.st, m_tuser);
                    errors++;
                end
            end
        end
    end

    function automatic void run_build(output logic [1:0] st);
        int n;
        logic [31:0] tot;
        logic [31:0] scl [DEPTH];
        int sq[$];
        int lq[$];
        int s, g;
        n = (slot_count < 1) ? 1 : (slot_count > DEPTH ? DEPTH : slot_count);
        tot = 0;
        for (int i = 0; i < n; i++) tot += w_mem[i];
        if (tot == 0) begin
            built = 0;
            st = RS_ZERO_TOTAL;
            return;
        end
        tot_w = tot[23:0];
        built_n = n;
        for (int i = 0; i < n; i++) begin
            ali_mem[i] = '0;
            thr_mem[i] = tot[23:0];
            scl[i] = w_mem[i] * n;
            if (scl[i] < tot) sq.push_back(i);
            else lq.push_back(i);
        end
        while (sq.size() > 0 && lq.size() > 0) begin
            s = sq.pop_front();
            g = lq.pop_front();
            thr_mem[s] = scl[s][23:0];
            ali_mem[s] = g[7:0];
            scl[g] = scl[g] + scl[s] - tot;
            if (scl[g] < tot) sq.push_back(g);
            else lq.push_back(g);
        end
        built = 1;
        st = RS_OK;
    endfunction

    function automatic pick_t sample_step(logic [1:0] fn, logic [7:0] slot,
                                          logic [15:0] wt, logic [15:0] frac);
        pick_t r;
        logic [PROD_BITS-1:0] lhs, rhs;
        r.idx = '0;
        r.st = RS_OK;
        case (fn)
            FN_WRITE: w_mem[slot] = wt;
            FN_BUILD: run_build(r.st);
            FN_LOOKUP: begin
                if (!built) r.st = RS_NOT_BUILT;
                else if (slot >= built_n) r.st = RS_RANGE;
                else begin
                    lhs = frac * tot_w;
                    rhs = {thr_mem[slot], 16'd0};
                    r.idx = (lhs < rhs) ? slot : ali_mem[slot];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // one input word through the handshake; sender gaps drawn by caller
    task automatic push_word(logic [1:0] fn, logic [7:0] slot, logic [15:0] wt,
                             logic [15:0] frac, bit fixed, logic [7:0] fi, logic [1:0] fs);
        pick_t p;
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {frac, wt, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = sample_step(fn, slot, wt, frac);
        if (fixed) begin
            if (p.idx !== fi || p.st !== fs) begin
                $error("directed row disagrees with predictor: idx %0d/%0d st %0d/%0d",
                       fi, p.idx, fs, p.st);
                errors++;
            end
            p.idx = fi;
            p.st = fs;
        end
        picks_due.push_back(p);
    endtask

    int burst = 0;
    task automatic send(logic [1:0] fn, logic [7:0] slot, logic [15:0] wt,
                        logic [15:0] frac, bit fixed = 0, logic [7:0] fi = 0,
                        logic [1:0] fs = 0);
        int gap;
        if (burst == 0) begin
            burst = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst--;
        push_word(fn, slot, wt, frac, fixed, fi, fs);
    endtask

    task automatic drain_and_set(int n);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (picks_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= n[CNT_BITS-1:0];
        @(posedge aclk);
        cfg_wen <= 1'b0;
        slot_count = n;
    endtask

    task automatic fill_weights(int n, int style);
        logic [15:0] w;
        for (int i = 0; i < n; i++) begin
            case (style)
                0: w = 16'($urandom_range(0, 65535));
                1: w = 16'($urandom_range(0, 20));
                2: w = (i % 3 == 0) ? 16'hFFFF : 16'd0;
                default: w = 16'($urandom_range(1, 4));
            endcase
            send(FN_WRITE, i[7:0], w, 16'($urandom_range(0, 65535)));
        end
    endtask

    dir_row_t dir_tab[$];
    int sizes[] = '{1, 2, 3, 5, 8, 16, 256, 255, 7, 2, 31, 64};

    initial begin
        int n, k, sent;
        for (int i = 0; i < DEPTH; i++) begin
            w_mem[i] = '0; thr_mem[i] = '0; ali_mem[i] = '0;
        end
        tot_w = '0; built = 0; built_n = 0; slot_count = 1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: fn, slot, weight, fraction, fixed expectation?
        dir_tab = '{
            '{FN_LOOKUP, 8'd0, 16'd0, 16'd0, 1, 8'd0, RS_NOT_BUILT},
            '{FN_LOOKUP, 8'd255, 16'd0, 16'hFFFF, 1, 8'd0, RS_NOT_BUILT},
            '{2'd3, 8'd9, 16'h1234, 16'h5678, 1, 8'd0, RS_OK},
            '{FN_WRITE, 8'd0, 16'd0, 16'd0, 1, 8'd0, RS_OK},
            '{FN_BUILD, 8'd0, 16'd0, 16'd0, 1, 8'd0, RS_ZERO_TOTAL},
            '{FN_LOOKUP, 8'd0, 16'd0, 16'd0, 1, 8'd0, RS_NOT_BUILT},
            '{FN_WRITE, 8'd0, 16'hFFFF, 16'hFFFF, 1, 8'd0, RS_OK},
            '{FN_WRITE, 8'd255, 16'd7, 16'd0, 1, 8'd0, RS_OK},
            '{FN_BUILD, 8'd0, 16'd0, 16'd0, 1, 8'd0, RS_OK},
            '{FN_LOOKUP, 8'd0, 16'd0, 16'hFFFF, 1, 8'd0, RS_OK},
            '{FN_LOOKUP, 8'd1, 16'd0, 16'd0, 1, 8'd0, RS_RANGE},
            '{FN_LOOKUP, 8'd255, 16'd0, 16'd0, 1, 8'd0, RS_RANGE}
        };
        foreach (dir_tab[i])
            push_word(dir_tab[i].fn, dir_tab[i].slot, dir_tab[i].wt, dir_tab[i].frac,
                      dir_tab[i].fixed, dir_tab[i].want_idx, dir_tab[i].want_st);

        // two slots, uneven weights; writes after a build leave the table alone
        drain_and_set(2);
        push_word(FN_WRITE, 8'd1, 16'd1, 0, 0, 0, 0);
        push_word(FN_BUILD, 0, 0, 0, 0, 0, 0);
        push_word(FN_LOOKUP, 8'd1, 0, 16'hFFFF, 0, 0, 0);
        push_word(FN_LOOKUP, 8'd1, 0, 16'h0000, 0, 0, 0);
        push_word(FN_WRITE, 8'd1, 16'hFFFF, 0, 0, 0, 0);
        push_word(FN_LOOKUP, 8'd1, 0, 16'h8000, 0, 0, 0);
        push_word(FN_LOOKUP, 8'd0, 0, 16'hAAAA, 0, 0, 0);
        // count change after a build only counts at the next build
        drain_and_set(256);
        push_word(FN_LOOKUP, 8'd2, 0, 0, 0, 0, 0);

        sent = 0;
        k = 0;
        while (sent < 950) begin
            n = (k < sizes.size()) ? sizes[k] : $urandom_range(1, 24);
            k++;
            drain_and_set(n);
            fill_weights(n, $urandom_range(0, 3));
            sent += n;
            send(FN_BUILD, 0, 0, 0);
            sent++;
            for (int j = 0; j < $urandom_range(10, 50); j++) begin
                case ($urandom_range(0, 15))
                    0: send(FN_WRITE, 8'($urandom_range(0, n - 1)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                    1: send(2'd3, 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                    2: send(FN_LOOKUP, 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                    3: send(FN_BUILD, 0, 0, 0);
                    default: send(FN_LOOKUP, 8'($urandom_range(0, n - 1)),
                                  16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 65535)));
                endcase
                sent++;
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (picks_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> files.f
rtl/ats_pkg.sv
rtl/ats_queue.sv
rtl/ats_ctrl.sv
rtl/ats_dp.sv
rtl/alias_table_sampler.sv
bench/alias_table_sampler_tb.sv
